[design/sct_pkg.sv]
// ----------------------------------------------------------------------------
// Sine / cosine Taylor unit package
// Shared constants, pipeline item types and elaboration-time helpers that
// derive the per-term reciprocal constants.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int SIN_TERMS     = 14;
   localparam int COS_TERMS     = 15;
   localparam int OUT_FRAC_BITS = 30;

   // Internal working format is unsigned or signed Q52.
   localparam int FRAC_BITS   = 52;
   localparam int MAX_TERMS   = (SIN_TERMS > COS_TERMS) ? SIN_TERMS : COS_TERMS;
   localparam int NUM_STEPS   = MAX_TERMS - 1;
   localparam int ROUND_SHIFT = FRAC_BITS - OUT_FRAC_BITS;

   // 2*pi in unsigned Q8.56, and the quotient bits the reduction needs for a
   // 32-bit magnitude placed in the top of a 64-bit word.
   localparam logic [63:0] TWO_PI_Q56   = 64'h06487ED5110B4612;
   localparam int          REDUCE_STEPS = 5;

   localparam int SHIFT_W = 4;

   // Last term leaves the term chain unsummed and is added at the output.
   localparam logic FINAL_SUB     = ((MAX_TERMS - 1) % 2) == 1;
   localparam logic FINAL_USE_SIN = (MAX_TERMS - 1) < SIN_TERMS;
   localparam logic FINAL_USE_COS = (MAX_TERMS - 1) < COS_TERMS;

   typedef struct packed {
      logic               valid;
      logic               cosine;
      logic               neg;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] sum;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic        cosine;
      logic        neg;
      logic [63:0] rem;
   } red_type;

   typedef struct packed {
      logic               sub;
      logic               use_sin;
      logic               use_cos;
      logic [63:0]        m_sin;
      logic [63:0]        m_cos;
      logic [SHIFT_W-1:0] l_sin;
      logic [SHIFT_W-1:0] l_cos;
   } term_ctl_type;

   function automatic int ceil_log2(input int d);
      int l;
      l = 0;
      for (int i = 0; i < 16; i++) begin
         if ((1 << i) < d) begin
            l = i + 1;
         end
      end
      return l;
   endfunction

   // Fractional part of ceil(2^(64+l) / d), the integer part being 2^64.
   function automatic logic [63:0] recip_frac(input int d);
      logic [79:0] num;
      logic [79:0] quo;
      logic [15:0] rem;
      logic [15:0] dv;
      int          l;
      l   = ceil_log2(d);
      num = 80'd1 << (64 + l);
      quo = '0;
      rem = '0;
      dv  = 16'(d);
      for (int i = 79; i >= 0; i--) begin
         rem = {rem[14:0], num[i]};
         if (rem >= dv) begin
            rem    = rem - dv;
            quo[i] = 1'b1;
         end
      end
      if (rem != '0) begin
         quo = quo + 80'd1;
      end
      return quo[63:0];
   endfunction

   // Constants for the term step that forms term j from term j-1.
   function automatic term_ctl_type term_ctl(input int j);
      int           ds;
      int           dc;
      term_ctl_type c;
      ds        = (2 * j + 1) * (2 * j);
      dc        = (2 * j) * (2 * j - 1);
      c.sub     = ((j - 1) % 2) == 1;
      c.use_sin = (j - 1) < SIN_TERMS;
      c.use_cos = (j - 1) < COS_TERMS;
      c.m_sin   = recip_frac(ds);
      c.m_cos   = recip_frac(dc);
      c.l_sin   = SHIFT_W'(ceil_log2(ds));
      c.l_cos   = SHIFT_W'(ceil_log2(dc));
      return c;
   endfunction

endpackage

[design/sct_mul64.sv]
// ----------------------------------------------------------------------------
// Two-stage 64 x 64 multiplier
// Four 32 x 32 partial products are registered, then summed into a
// registered 128-bit product.
// ----------------------------------------------------------------------------
module sct_mul64 (
   input  logic          clock,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic [127:0]  product
);

   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [127:0] product_in;
   logic [127:0] product_ff;

   always_ff @(posedge clock) begin
      pp00_ff    <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01_ff    <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10_ff    <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11_ff    <= 64'(a[63:32]) * 64'(b[63:32]);
      product_ff <= product_in;
   end

   assign product_in = {64'b0, pp00_ff} + {32'b0, pp01_ff, 32'b0}
                     + {32'b0, pp10_ff, 32'b0} + {pp11_ff, 64'b0};
   assign product = product_ff;

endmodule

[design/sct_reduce.sv]
// ----------------------------------------------------------------------------
// Angle range reduction
// Takes the magnitude of the angle and removes multiples of 2*pi with one
// restoring compare-and-subtract per pipeline stage.
// ----------------------------------------------------------------------------
module sct_reduce import sct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_cosine,
   input  logic signed [31:0] in_angle,
   output red_type            out
);

   red_type     stage_ff [REDUCE_STEPS+1];
   red_type     stage_in [REDUCE_STEPS+1];
   logic [31:0] mag;

   always_comb begin
      mag = in_angle[31] ? (~in_angle + 32'd1) : in_angle;
      stage_in[0].valid  = in_valid;
      stage_in[0].cosine = in_cosine;
      stage_in[0].neg    = in_angle[31];
      stage_in[0].rem    = {mag, 32'b0};
      for (int k = 1; k <= REDUCE_STEPS; k++) begin
         stage_in[k] = stage_ff[k-1];
         if (stage_ff[k-1].rem >= (TWO_PI_Q56 << (REDUCE_STEPS - k))) begin
            stage_in[k].rem = stage_ff[k-1].rem - (TWO_PI_Q56 << (REDUCE_STEPS - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= REDUCE_STEPS; k++) begin
         stage_ff[k] <= stage_in[k];
      end
      if (reset) begin
         for (int k = 0; k <= REDUCE_STEPS; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end
   end

   assign out = stage_ff[REDUCE_STEPS];

endmodule

[design/sct_term.sv]
// ----------------------------------------------------------------------------
// Taylor term step
// Adds or subtracts the incoming term to the running sum where used,
// and forms the next term floor(floor(t * x^2) / (e * (e - 1))) by reciprocal.
// ----------------------------------------------------------------------------
module sct_term import sct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  term_ctl_type ctl,
   input  item_type     in,
   output item_type     out
);

   item_type     s1_ff, s2_ff, s3_ff, s4_ff, out_ff;
   item_type     s1_in, s3_in, out_in;
   logic [127:0] prod_a;
   logic [127:0] prod_b;
   logic [63:0]  recip;
   logic [64:0]  quo_sum;
   logic         used;

   sct_mul64 mul_sq (
      .clock   (clock),
      .a       (in.t),
      .b       (in.x2),
      .product (prod_a)
   );

   assign recip = s2_ff.cosine ? ctl.m_cos : ctl.m_sin;

   sct_mul64 mul_recip (
      .clock   (clock),
      .a       (prod_a[FRAC_BITS+63:FRAC_BITS]),
      .b       (recip),
      .product (prod_b)
   );

   always_comb begin
      used  = in.cosine ? ctl.use_cos : ctl.use_sin;
      s1_in = in;
      if (used) begin
         s1_in.sum = ctl.sub ? (in.sum - signed'(in.t)) : (in.sum + signed'(in.t));
      end

      s3_in   = s2_ff;
      s3_in.t = prod_a[FRAC_BITS+63:FRAC_BITS];

      // The reciprocal carries an implicit 2^64, hence the extra t term.
      quo_sum  = {1'b0, s4_ff.t} + {1'b0, prod_b[127:64]};
      out_in   = s4_ff;
      out_in.t = 64'(quo_sum >> (s4_ff.cosine ? ctl.l_cos : ctl.l_sin));
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s1_ff;
      s3_ff  <= s3_in;
      s4_ff  <= s3_ff;
      out_ff <= out_in;
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end
   end

   assign out = out_ff;

endmodule

[design/sct_output.sv]
// ----------------------------------------------------------------------------
// Result formatting
// Adds the last term when the operation uses it, applies the odd symmetry of
// sine, rounds to the output format and saturates to 32 bits.
// ----------------------------------------------------------------------------
module sct_output import sct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  item_type           in,
   output logic               out_valid,
   output logic signed [31:0] out_value
);

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic               s1_flip_ff;
   logic signed [63:0] s1_sum_ff, s2_sum_ff, s3_val_ff;
   logic signed [31:0] s4_value_ff;
   logic signed [63:0] s1_sum_in;
   logic signed [63:0] s3_val_in;
   logic signed [31:0] s4_value_in;
   logic               used;

   always_comb begin
      used      = in.cosine ? FINAL_USE_COS : FINAL_USE_SIN;
      s1_sum_in = in.sum;
      if (used) begin
         s1_sum_in = FINAL_SUB ? (in.sum - signed'(in.t)) : (in.sum + signed'(in.t));
      end
   end

   if (ROUND_SHIFT > 0) begin : g_round
      localparam logic signed [63:0] HALF = 64'sd1 <<< (ROUND_SHIFT - 1);
      assign s3_val_in = (s2_sum_ff + HALF) >>> ROUND_SHIFT;
   end else if (ROUND_SHIFT < 0) begin : g_scale
      localparam int                 UP  = -ROUND_SHIFT;
      localparam logic signed [63:0] LIM = 64'sd1 <<< FRAC_BITS;
      logic signed [63:0] clamped;
      always_comb begin
         clamped = s2_sum_ff;
         if (s2_sum_ff > LIM) begin
            clamped = LIM;
         end
         if (s2_sum_ff < -LIM) begin
            clamped = -LIM;
         end
      end
      assign s3_val_in = clamped <<< UP;
   end else begin : g_same
      assign s3_val_in = s2_sum_ff;
   end

   always_comb begin
      if (s3_val_ff > 64'sd2147483647) begin
         s4_value_in = 32'sh7FFFFFFF;
      end else if (s3_val_ff < -64'sd2147483648) begin
         s4_value_in = 32'sh80000000;
      end else begin
         s4_value_in = s3_val_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_valid_ff <= in.valid;
      s1_flip_ff  <= in.neg & ~in.cosine;
      s1_sum_ff   <= s1_sum_in;
      s2_valid_ff <= s1_valid_ff;
      s2_sum_ff   <= s1_flip_ff ? -s1_sum_ff : s1_sum_ff;
      s3_valid_ff <= s2_valid_ff;
      s3_val_ff   <= s3_val_in;
      s4_valid_ff <= s3_valid_ff;
      s4_value_ff <= s4_value_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_value = s4_value_ff;

endmodule

[design/sine_cosine_taylor_unit.sv]
// ----------------------------------------------------------------------------
// Sine / cosine Taylor series unit
// Fully pipelined sine or cosine of a Q8.24 angle, result in Q2.30.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle and returns exactly one result
// per item, in order. Each item passes through range reduction, squaring of
// the reduced angle, the 14 term steps and rounding and saturation. Most of
// the pipeline is the chain of term steps, each of which holds two pipelined
// 64 x 64 multipliers (one for t * x^2, one for the reciprocal that divides by
// e * (e - 1)). The result is shown on rsp_value for a single cycle while
// rsp_valid is high; the receiver cannot hold it off, so it must take every
// result as it comes. busy is high only during reset; otherwise start is
// accepted in every cycle.
//
// The angle is reduced modulo 2*pi with the quotient truncated toward zero,
// so the remainder keeps the sign of the angle. Sine of a negative angle is
// the negated sine of its magnitude, cosine uses the magnitude directly.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_unit import sct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value
);

   red_type      red;
   item_type     front1_ff, front2_ff;
   item_type     front1_in;
   item_type     chain [NUM_STEPS+1];
   logic [63:0]  x;
   logic [127:0] x_sq;

   assign busy = reset;

   // Range reduction: the magnitude, then one quotient bit per stage.
   sct_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_cosine (req_operation),
      .in_angle  (req_angle),
      .out       (red)
   );

   // Reduced angle from Q56 down to the Q52 working format.
   assign x = {4'b0, red.rem[63:4]};

   sct_mul64 u_square (
      .clock   (clock),
      .a       (x),
      .b       (x),
      .product (x_sq)
   );

   // The first term is x for sine and 1.0 for cosine; it travels alongside
   // the squaring multiplier so the two meet at the first term step.
   always_comb begin
      front1_in.valid  = red.valid;
      front1_in.cosine = red.cosine;
      front1_in.neg    = red.neg;
      front1_in.x2     = '0;
      front1_in.t      = red.cosine ? (64'd1 << FRAC_BITS) : x;
      front1_in.sum    = '0;
   end

   always_ff @(posedge clock) begin
      front1_ff <= front1_in;
      front2_ff <= front1_ff;
      if (reset) begin
         front1_ff.valid <= 1'b0;
         front2_ff.valid <= 1'b0;
      end
   end

   always_comb begin
      chain[0]    = front2_ff;
      chain[0].x2 = x_sq[FRAC_BITS+63:FRAC_BITS];
   end

   // Term steps: step j sums term j-1 and forms term j.
   for (genvar j = 1; j <= NUM_STEPS; j++) begin : g_term
      localparam term_ctl_type CTL = term_ctl(j);
      sct_term u_term (
         .clock (clock),
         .reset (reset),
         .ctl   (CTL),
         .in    (chain[j-1]),
         .out   (chain[j])
      );
   end

   // Last term, symmetry, rounding and saturation.
   sct_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in        (chain[NUM_STEPS]),
      .out_valid (rsp_valid),
      .out_value (rsp_value)
   );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine / cosine Taylor unit testbench
// Drives directed and random angles with both operations, predicts every
// result with an independent fixed-point model and checks results in order.
// ----------------------------------------------------------------------------
module testbench import sct_pkg::*;;

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;
   localparam int   LATENCY   = 82;
   localparam logic [63:0] TWO_PI_FIX = 64'h06487ED5110B4612;

   typedef struct packed {
      logic        operation;
      logic [31:0] angle;
   } angle_item_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic signed [31:0] req_angle;
   logic               rsp_valid;
   logic signed [31:0] rsp_value;

   angle_item_t pending_items[$];
   logic [31:0] expected_values[$];
   int          mismatches;
   int          send_idle_pct;

   sine_cosine_taylor_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_angle(req_angle),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor(a * b / 2^52) using a full-width product.
   function automatic logic [63:0] mul_q52(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[115:52];
   endfunction

   // Sine or cosine of one item: reduce modulo 2*pi, sum the alternating series
   // in signed Q52, then round half up to Q2.30 and saturate.
   function automatic logic [31:0] taylor_value(input angle_item_t it);
      logic               cosine;
      logic               neg;
      logic [63:0]        mag;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic [63:0]        e;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      int                 terms;
      cosine = it.operation;
      neg    = it.angle[31];
      mag    = neg ? (64'd1 << 32) - {32'd0, it.angle} : {32'd0, it.angle};
      x      = ((mag << 32) % TWO_PI_FIX) >> 4;
      x2     = mul_q52(x, x);
      terms  = cosine ? COS_TERMS : SIN_TERMS;
      t      = cosine ? (64'd1 << 52) : x;
      e      = cosine ? 64'd0 : 64'd1;
      sum    = '0;
      for (int k = 0; k < terms; k++) begin
         if (k % 2 == 1) sum = sum - $signed(t);
         else sum = sum + $signed(t);
         if (k + 1 < terms) begin
            e = e + 2;
            t = mul_q52(t, x2) / (e * (e - 1));
         end
      end
      if (!cosine && neg) sum = -sum;
      v = (sum + (64'sd1 <<< 21)) >>> 22;
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      return v[31:0];
   endfunction

   function automatic angle_item_t random_item();
      angle_item_t it;
      it.operation = 1'($urandom_range(1, 0));
      case ($urandom_range(3, 0))
         0: it.angle = $urandom;
         1: it.angle = $urandom_range(32'h0C00_0000, 0) - 32'h0600_0000;
         2: it.angle = $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
         default: it.angle = ($urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_0000)
                             + $urandom_range(32'hFFFF, 0);
      endcase
      return it;
   endfunction

   // Driver: raises start with the next item, or idles send_idle_pct percent of
   // the time; each item is accepted at an edge where busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            angle_item_t it;
            it = pending_items.pop_front();
            start         <= 1'b1;
            req_operation <= it.operation;
            req_angle     <= it.angle;
            expected_values.push_back(taylor_value(it));
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result %h with nothing outstanding", rsp_value);
         end else begin
            logic [31:0] want;
            want = expected_values.pop_front();
            if (rsp_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Value mismatch: expected %h, got %h", want, rsp_value);
            end
         end
      end
   end

   task automatic run_phase(input int idle_pct, input int count);
      send_idle_pct = idle_pct;
      repeat (count) pending_items.push_back(random_item());
      while (pending_items.size() > 0 || start) @(posedge clock);
   endtask

   initial begin
      logic [31:0] corners[10];
      angle_item_t it;
      corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0001, 32'h0648_7ED5, 32'hF9B7_812B,
                  32'h0192_1FB5, 32'h0324_3F6A};
      mismatches    = 0;
      send_idle_pct = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = 1'b0;
      req_angle     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme angles, multiples of pi/2 and 2*pi, both operations.
      foreach (corners[i]) begin
         it.angle     = corners[i];
         it.operation = OP_SINE;
         pending_items.push_back(it);
         it.operation = OP_COSINE;
         pending_items.push_back(it);
      end
      run_phase(0, 0);

      run_phase(8, 340);
      run_phase(69, 330);
      run_phase(0, 330);

      while (expected_values.size() > 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
design/sct_pkg.sv
design/sct_mul64.sv
design/sct_reduce.sv
design/sct_term.sv
design/sct_output.sv
design/sine_cosine_taylor_unit.sv
bench/testbench.sv
